// File: design/ffba_pkg.sv
// ffba_pkg: shared types and codes for the first-fit block allocator
// used by ffba_cell and first_fit_block_allocator_core; no dependencies
package ffba_pkg;

    // command codes
    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_REALLOC = 2'd2;
    localparam logic [1:0] CMD_DEFRAG  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOMEM = 2'd1;
    localparam logic [1:0] ST_BADH  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam int TAG_BITS = 5;

    // per-cell shift control
    typedef enum logic [1:0] {
        SH_HOLD  = 2'd0,
        SH_LEFT  = 2'd1,
        SH_RIGHT = 2'd2,
        SH_LOAD  = 2'd3
    } shift_t;

endpackage

// File: design/first_fit_block_allocator_core.sv
// Block allocator over a row of MAX_BLOCKS table cells sorted by offset, with
// a sequencer that walks the row one entry a cycle. A realloc that moves
// does a free pass then a placement pass. Defragment emits one result per
// cycle while out stall is low. Time is set by the single scan pointer that
// visits one cell per cycle, and by shifts of the cell row. Only one item is
// worked at a time; the result sits in an output register and the next item
// waits until that result is taken.
// depends on ffba_pkg and ffba_cell
module first_fit_block_allocator_core #(
    parameter int MAX_BLOCKS = 32,
    parameter int ADDR_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [4:0]  handle,
    input  logic [15:0] req_size,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [4:0]  out_handle,
    output logic [15:0] block_offset,
    output logic [15:0] old_offset,
    output logic [15:0] block_size,
    output logic        last
);

    localparam int IW      = $clog2(MAX_BLOCKS);
    localparam int CW      = $clog2(MAX_BLOCKS + 1);
    localparam int TW      = ffba_pkg::TAG_BITS;
    localparam int TAG_CAP = (MAX_BLOCKS < 32) ? MAX_BLOCKS : 32;
    localparam int AW      = ADDR_BITS;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FIND  = 7'b0000010,
        S_FREE  = 7'b0000100,
        S_PLACE = 7'b0001000,
        S_INS   = 7'b0010000,
        S_DEFR  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   pool_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic [31:0]     inuse_reg, inuse_next;
    logic [CW-1:0]   ptr_reg, ptr_next;
    logic [1:0]      cmd_reg, cmd_next;
    logic [TW-1:0]   h_reg, h_next;
    logic [AW-1:0]   sz_reg, sz_next;
    logic [AW-1:0]   base_reg, base_next;
    logic [AW-1:0]   oldo_reg, oldo_next;
    logic            ov_reg, ov_next;
    logic [1:0]      st_reg, st_next;
    logic [TW-1:0]   oh_reg, oh_next;
    logic [AW-1:0]   bo_reg, bo_next;
    logic [AW-1:0]   oo_reg, oo_next;
    logic [AW-1:0]   bs_reg, bs_next;
    logic            last_reg, last_next;

    ffba_pkg::shift_t  ctl    [MAX_BLOCKS];
    logic [AW-1:0]     c_off  [MAX_BLOCKS];
    logic [AW-1:0]     c_size [MAX_BLOCKS];
    logic [TW-1:0]     c_tag  [MAX_BLOCKS];
    logic [AW-1:0]     ld_off, ld_size;
    logic [TW-1:0]     ld_tag;
    logic [CW-1:0]     shift_pos;
    logic              do_right, do_left, do_load;

    // row of table cells
    genvar g;
    generate
        for (g = 0; g < MAX_BLOCKS; g++)
        begin : g_cell
            ffba_cell #(.AW(AW)) u_cell (
                .clk        (clk),
                .ctl        (ctl[g]),
                .left_off   (c_off[(g == 0) ? 0 : g - 1]),
                .left_size  (c_size[(g == 0) ? 0 : g - 1]),
                .left_tag   (c_tag[(g == 0) ? 0 : g - 1]),
                .right_off  (c_off[(g == MAX_BLOCKS - 1) ? g : g + 1]),
                .right_size (c_size[(g == MAX_BLOCKS - 1) ? g : g + 1]),
                .right_tag  (c_tag[(g == MAX_BLOCKS - 1) ? g : g + 1]),
                .load_off   (ld_off),
                .load_size  (ld_size),
                .load_tag   (ld_tag),
                .off        (c_off[g]),
                .size       (c_size[g]),
                .tag        (c_tag[g])
            );
        end
    endgenerate

    // per-cell control from the sequencer's shift request
    always_comb
    begin
        for (int k = 0; k < MAX_BLOCKS; k++)
        begin
            ctl[k] = ffba_pkg::SH_HOLD;
            if (do_load && CW'(k) == shift_pos)
                ctl[k] = ffba_pkg::SH_LOAD;
            else if (do_right && CW'(k) > shift_pos && CW'(k) <= count_reg)
                ctl[k] = ffba_pkg::SH_RIGHT;
            else if (do_left && CW'(k) >= shift_pos && CW'(k) + 1'b1 < count_reg)
                ctl[k] = ffba_pkg::SH_LEFT;
        end
    end

    // scan view of the entry under the pointer and its predecessor
    logic [IW-1:0]   pi, pim1;
    logic [AW-1:0]   cur_off, cur_size, prv_off, prv_size;
    logic [TW-1:0]   cur_tag;
    logic [AW:0]     gap_start, gap_end, need;
    logic [TW-1:0]   free_tag;
    logic            ptr_lt_cnt;

    assign pi       = ptr_reg[IW-1:0];
    assign pim1     = pi - 1'b1;
    assign cur_off  = c_off[pi];
    assign cur_size = c_size[pi];
    assign cur_tag  = c_tag[pi];
    assign prv_off  = c_off[pim1];
    assign prv_size = c_size[pim1];
    assign ptr_lt_cnt = ptr_reg < count_reg;
    assign gap_start = (ptr_reg == '0) ? '0 : ({1'b0, prv_off} + {1'b0, prv_size});
    assign gap_end   = ptr_lt_cnt ? {1'b0, cur_off} : {1'b0, pool_reg};
    assign need      = gap_start + {1'b0, sz_reg};

    // lowest clear tag
    always_comb
    begin
        free_tag = '0;
        for (int t = 31; t >= 0; t--)
            if (!inuse_reg[t])
                free_tag = TW'(t);
    end

    logic         accept;
    logic         out_take;
    logic         ovf_pos;
    logic [AW:0]  next_end;

    // a waiting result holds off the next item
    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign accept    = in_valid && !in_stall;
    assign out_take  = ov_reg && !out_stall;
    assign ovf_pos   = (ptr_reg + 1'b1) < count_reg;
    assign next_end  = ovf_pos ? {1'b0, c_off[IW'(ptr_reg + 1'b1)]} : {1'b0, pool_reg};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        inuse_next = inuse_reg;
        ptr_next   = ptr_reg;
        cmd_next   = cmd_reg;
        h_next     = h_reg;
        sz_next    = sz_reg;
        base_next  = base_reg;
        oldo_next  = oldo_reg;
        ov_next    = ov_reg;
        st_next    = st_reg;
        oh_next    = oh_reg;
        bo_next    = bo_reg;
        oo_next    = oo_reg;
        bs_next    = bs_reg;
        last_next  = last_reg;
        do_right   = 1'b0;
        do_left    = 1'b0;
        do_load    = 1'b0;
        shift_pos  = ptr_reg;
        ld_off     = gap_start[AW-1:0];
        ld_size    = sz_reg;
        ld_tag     = h_reg;
        if (out_take)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = cmd;
                    h_next    = handle;
                    sz_next   = AW'(req_size);
                    ptr_next  = '0;
                    base_next = '0;
                    state_next = (cmd == ffba_pkg::CMD_DEFRAG) ? S_DEFR : S_FIND;
                end
            end
            S_FIND:
            begin
                if (cmd_reg == ffba_pkg::CMD_ALLOC
                    || !inuse_reg[h_reg] || !ptr_lt_cnt)
                begin
                    if (cmd_reg == ffba_pkg::CMD_FREE)
                    begin
                        st_next = ffba_pkg::ST_BADH; oh_next = '0; bo_next = '0;
                        oo_next = '0; bs_next = '0; state_next = S_OUT;
                    end
                    else if (count_reg >= CW'(TAG_CAP))
                    begin
                        st_next = ffba_pkg::ST_FULL; oh_next = '0; bo_next = '0;
                        oo_next = '0; bs_next = '0; state_next = S_OUT;
                    end
                    else
                    begin
                        h_next = free_tag; oldo_next = '0;
                        ptr_next = '0; state_next = S_PLACE;
                    end
                end
                else if (cur_tag == h_reg)
                begin
                    if (cmd_reg == ffba_pkg::CMD_FREE)
                    begin
                        st_next = ffba_pkg::ST_OK; oh_next = h_reg; bo_next = cur_off;
                        oo_next = '0; bs_next = cur_size; state_next = S_FREE;
                    end
                    else if ({1'b0, cur_off} + {1'b0, sz_reg} <= next_end)
                    begin
                        // resize in place rewrites the cell under the pointer
                        do_load = 1'b1; ld_off = cur_off;
                        st_next = ffba_pkg::ST_OK; oh_next = h_reg; bo_next = cur_off;
                        oo_next = cur_off; bs_next = sz_reg; state_next = S_OUT;
                    end
                    else
                    begin
                        oldo_next = cur_off; state_next = S_FREE;
                    end
                end
                else
                    ptr_next = ptr_reg + 1'b1;
            end
            S_FREE:
            begin
                // remove the entry under the pointer
                do_left = 1'b1;
                count_next = count_reg - 1'b1;
                inuse_next[h_reg] = 1'b0;
                if (cmd_reg == ffba_pkg::CMD_FREE)
                    state_next = S_OUT;
                else
                begin
                    ptr_next = '0; state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                if (need <= gap_end)
                begin
                    state_next = S_INS;
                    base_next  = gap_start[AW-1:0];
                end
                else if (!ptr_lt_cnt)
                begin
                    st_next = ffba_pkg::ST_NOMEM; oh_next = '0; bo_next = '0;
                    oo_next = '0; bs_next = '0; state_next = S_OUT;
                end
                else
                    ptr_next = ptr_reg + 1'b1;
            end
            S_INS:
            begin
                do_right = 1'b1; do_load = 1'b1; ld_off = base_reg;
                count_next = count_reg + 1'b1;
                inuse_next[h_reg] = 1'b1;
                st_next = ffba_pkg::ST_OK; oh_next = h_reg; bo_next = base_reg;
                oo_next = oldo_reg; bs_next = sz_reg; state_next = S_OUT;
            end
            S_DEFR:
            begin
                if (!ov_reg || out_take)
                begin
                    if (count_reg == '0)
                    begin
                        st_next = ffba_pkg::ST_OK; oh_next = '0; bo_next = '0;
                        oo_next = '0; bs_next = '0; last_next = 1'b1;
                        ov_next = 1'b1; state_next = S_IDLE;
                    end
                    else
                    begin
                        do_load = 1'b1; ld_off = base_reg;
                        ld_size = cur_size; ld_tag = cur_tag;
                        st_next = ffba_pkg::ST_OK; oh_next = cur_tag; bo_next = base_reg;
                        oo_next = cur_off; bs_next = cur_size;
                        last_next = (ptr_reg + 1'b1) == count_reg;
                        ov_next = 1'b1;
                        base_next = base_reg + cur_size;
                        ptr_next = ptr_reg + 1'b1;
                        if ((ptr_reg + 1'b1) == count_reg)
                            state_next = S_IDLE;
                    end
                end
            end
            S_OUT:
            begin
                if (!ov_reg || out_take)
                begin
                    ov_next = 1'b1; last_next = 1'b1; state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pool_reg  <= AW'(16'hFFFF);
            count_reg <= '0;
            inuse_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                pool_reg <= AW'(cfg_wdata);
            count_reg <= count_next;
            inuse_reg <= inuse_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        cmd_reg  <= cmd_next;
        h_reg    <= h_next;
        sz_reg   <= sz_next;
        base_reg <= base_next;
        oldo_reg <= oldo_next;
        st_reg   <= st_next;
        oh_reg   <= oh_next;
        bo_reg   <= bo_next;
        oo_reg   <= oo_next;
        bs_reg   <= bs_next;
        last_reg <= last_next;
    end

    assign out_valid    = ov_reg;
    assign status       = st_reg;
    assign out_handle   = oh_reg;
    assign block_offset = 16'(bo_reg);
    assign old_offset   = 16'(oo_reg);
    assign block_size   = 16'(bs_reg);
    assign last         = last_reg;

`ifndef SYNTHESIS
    // table never holds more entries than it has cells
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_BLOCKS))
        else $error("entry count above table depth");

    // a new item is only taken when the sequencer is idle and always starts work
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("item accepted without starting work");

    // a held result does not change while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> (ov_reg && $stable(bo_reg) && $stable(oh_reg)))
        else $error("stalled result changed");
`endif

endmodule

// File: design/ffba_cell.sv
// ffba_cell: one table entry (offset, size, tag) of the sorted block list
// depends on ffba_pkg for the shift control type
module ffba_cell #(
    parameter int AW = 16
) (
    input  logic                         clk,
    input  ffba_pkg::shift_t             ctl,
    input  logic [AW-1:0]                left_off,
    input  logic [AW-1:0]                left_size,
    input  logic [ffba_pkg::TAG_BITS-1:0] left_tag,
    input  logic [AW-1:0]                right_off,
    input  logic [AW-1:0]                right_size,
    input  logic [ffba_pkg::TAG_BITS-1:0] right_tag,
    input  logic [AW-1:0]                load_off,
    input  logic [AW-1:0]                load_size,
    input  logic [ffba_pkg::TAG_BITS-1:0] load_tag,
    output logic [AW-1:0]                off,
    output logic [AW-1:0]                size,
    output logic [ffba_pkg::TAG_BITS-1:0] tag
);

    logic [AW-1:0]                off_reg, off_next;
    logic [AW-1:0]                size_reg, size_next;
    logic [ffba_pkg::TAG_BITS-1:0] tag_reg, tag_next;

    // select source: keep, take from lower neighbor, upper neighbor or load
    always_comb
    begin
        off_next  = off_reg;
        size_next = size_reg;
        tag_next  = tag_reg;
        case (ctl)
            ffba_pkg::SH_LEFT:
            begin
                off_next  = right_off;
                size_next = right_size;
                tag_next  = right_tag;
            end
            ffba_pkg::SH_RIGHT:
            begin
                off_next  = left_off;
                size_next = left_size;
                tag_next  = left_tag;
            end
            ffba_pkg::SH_LOAD:
            begin
                off_next  = load_off;
                size_next = load_size;
                tag_next  = load_tag;
            end
            default:
            begin
                off_next  = off_reg;
                size_next = size_reg;
                tag_next  = tag_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        off_reg  <= off_next;
        size_reg <= size_next;
        tag_reg  <= tag_next;
    end

    assign off  = off_reg;
    assign size = size_reg;
    assign tag  = tag_reg;

endmodule
